// File: rtl/core/mm4_pkg.sv
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared constants and types of the 4x4 fixed-point matrix multiply unit.
// ----------------------------------------------------------------------------
package mm4_pkg;

  // default geometry and fixed-point format
  localparam int unsigned MATRIX_DIM_DEF = 4;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // element word, signed Q16.16
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned PROD_W = 2 * ELEM_W;

  localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  // tag that travels alongside a store read into the MAC
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } mac_tag_t;

endpackage

// File: rtl/core/mm4_if.sv
// ----------------------------------------------------------------------------
// mm4_if
// Valid/ready channels: element words in, product words out.
// ----------------------------------------------------------------------------
interface mm4_elem_if;
  import mm4_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

interface mm4_prod_if;
  import mm4_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] product_value;
  logic                     product_last;

  modport source (output valid, output product_value, output product_last, input ready);
  modport sink   (input valid, input product_value, input product_last, output ready);
endinterface

// File: rtl/core/mm4_store.sv
// ----------------------------------------------------------------------------
// mm4_store
// Matrix store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mm4_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/mm4_mac.sv
// ----------------------------------------------------------------------------
// mm4_mac
// Shared multiply-accumulate: registered product, exact sum, shift, saturate.
// ----------------------------------------------------------------------------
module mm4_mac #(
  parameter int unsigned MATRIX_DIM = mm4_pkg::MATRIX_DIM_DEF,
  parameter int unsigned FRAC_BITS  = mm4_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mm4_pkg::mac_tag_t                tag_i,
  input  logic signed [mm4_pkg::ELEM_W-1:0] a_i,
  input  logic signed [mm4_pkg::ELEM_W-1:0] b_i,
  input  logic                             clr_i,
  output logic                             done_o,
  output logic [mm4_pkg::ELEM_W-1:0]       result_o
);
  import mm4_pkg::*;

  // room for MATRIX_DIM full-scale products without wrap
  localparam int unsigned ACC_W = PROD_W + $clog2(MATRIX_DIM);

  mac_tag_t                  mul_tag_q;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [ACC_W-1:0]   acc_d, acc_q;
  logic signed [ACC_W-1:0]   prod_ext;
  logic signed [ACC_W-1:0]   shifted;
  logic [ACC_W-ELEM_W:0]     upper;
  logic                      pos_ovf, neg_ovf;
  logic                      done_q;

  assign prod_d   = a_i * b_i;
  assign prod_ext = {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_d    = mul_tag_q.first ? prod_ext : acc_q + prod_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_tag_q <= '0;
      done_q    <= 1'b0;
    end else begin
      mul_tag_q <= tag_i;
      if (mul_tag_q.vld && mul_tag_q.last) begin
        done_q <= 1'b1;
      end else if (clr_i) begin
        done_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (mul_tag_q.vld) begin
      acc_q <= acc_d;
    end
  end

  // floor shift, then clamp when the bits above the sign do not agree
  assign shifted = acc_q >>> FRAC_BITS;
  assign upper   = shifted[ACC_W-1:ELEM_W-1];
  assign pos_ovf = !shifted[ACC_W-1] && (|upper);
  assign neg_ovf = shifted[ACC_W-1] && !(&upper);

  always_comb begin
    priority if (pos_ovf) begin
      result_o = SAT_MAX;
    end else if (neg_ovf) begin
      result_o = SAT_MIN;
    end else begin
      result_o = shifted[ELEM_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

// File: rtl/core/matrix4_multiply_unit.sv
// ----------------------------------------------------------------------------
// matrix4_multiply_unit
// Fixed-point square matrix product: loads left then right matrix, column-
// major, one element word per transfer, then streams left x right.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                       | notes
//  ---------+-----+-------------------------------+---------------------------
//  elem_i   | in  | element_value (s32, Q16.16)   | 2*DIM^2 words per batch
//  prod_o   | out | product_value (s32), last     | DIM^2 words, column-major
//
//  Load: one element word per cycle while elem_i is valid in the load phase.
//  Compute: each product word takes MATRIX_DIM reads on the single read port
//  of each store, then passes the store read register, the multiplier
//  register and the accumulator, and waits for a free output register.
//  Reset clears only control; the stores are not reset (read only after load).
//  The output register holds a word while prod_o stalls; the next batch's
//  load may start while the final product word still waits there.
//
module matrix4_multiply_unit #(
  parameter int unsigned MATRIX_DIM = mm4_pkg::MATRIX_DIM_DEF,
  parameter int unsigned FRAC_BITS  = mm4_pkg::FRAC_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mm4_elem_if.sink   elem_i,
  mm4_prod_if.source prod_o
);
  import mm4_pkg::*;

  localparam int unsigned ELEM_CNT = MATRIX_DIM * MATRIX_DIM;
  localparam int unsigned AW       = $clog2(ELEM_CNT);
  localparam int unsigned CW       = $clog2(2 * ELEM_CNT);
  localparam int unsigned KW       = $clog2(MATRIX_DIM);

  // load phase, read issue for one product word, wait for its sum and a free output register
  typedef enum logic [2:0] {
    S_LOAD  = 3'b001,
    S_ISSUE = 3'b010,
    S_WAIT  = 3'b100
  } state_e;

  state_e                   state_d, state_q;
  logic [CW-1:0]            load_cnt_d, load_cnt_q;
  logic [CW-1:0]            right_cnt;
  logic [KW-1:0]            k_d, k_q, row_d, row_q, col_d, col_q;
  mac_tag_t                 rd_tag_d, rd_tag_q;
  logic                     out_vld_d, out_vld_q;
  logic [ELEM_W-1:0]        out_val_q;
  logic                     out_last_q;

  logic                     in_acc, is_left, load_last;
  logic                     k_last, row_last, col_last, elem_last;
  logic                     out_free, out_load;
  logic [AW-1:0]            left_raddr, right_raddr;
  logic [ELEM_W-1:0]        left_rdata, right_rdata;
  logic                     mac_done;
  logic [ELEM_W-1:0]        mac_result;

  // --- load side --------------------------------------------------------
  assign elem_i.ready = (state_q == S_LOAD);
  assign in_acc       = elem_i.valid && elem_i.ready;
  assign is_left      = load_cnt_q < CW'(ELEM_CNT);
  assign load_last    = load_cnt_q == CW'(2 * ELEM_CNT - 1);
  assign right_cnt    = load_cnt_q - CW'(ELEM_CNT);

  // --- compute side -----------------------------------------------------
  assign k_last    = k_q == KW'(MATRIX_DIM - 1);
  assign row_last  = row_q == KW'(MATRIX_DIM - 1);
  assign col_last  = col_q == KW'(MATRIX_DIM - 1);
  assign elem_last = row_last && col_last;

  // L(row,k) sits at k*DIM+row, R(k,col) at col*DIM+k
  assign left_raddr  = AW'(AW'(k_q) * AW'(MATRIX_DIM) + AW'(row_q));
  assign right_raddr = AW'(AW'(col_q) * AW'(MATRIX_DIM) + AW'(k_q));

  assign rd_tag_d.vld   = (state_q == S_ISSUE);
  assign rd_tag_d.first = (state_q == S_ISSUE) && (k_q == '0);
  assign rd_tag_d.last  = (state_q == S_ISSUE) && k_last;

  assign out_free = !out_vld_q || prod_o.ready;
  assign out_load = (state_q == S_WAIT) && mac_done && out_free;

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    k_d        = k_q;
    row_d      = row_q;
    col_d      = col_q;
    unique case (state_q)
      S_LOAD: begin
        if (in_acc) begin
          if (load_last) begin
            load_cnt_d = '0;
            state_d    = S_ISSUE;
          end else begin
            load_cnt_d = load_cnt_q + CW'(1);
          end
        end
      end
      S_ISSUE: begin
        if (k_last) begin
          k_d     = '0;
          state_d = S_WAIT;
        end else begin
          k_d = k_q + KW'(1);
        end
      end
      S_WAIT: begin
        if (out_load) begin
          if (elem_last) begin
            row_d   = '0;
            col_d   = '0;
            state_d = S_LOAD;
          end else begin
            state_d = S_ISSUE;
            if (row_last) begin
              row_d = '0;
              col_d = col_q + KW'(1);
            end else begin
              row_d = row_q + KW'(1);
            end
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_load) begin
      out_vld_d = 1'b1;
    end else if (prod_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      load_cnt_q <= '0;
      k_q        <= '0;
      row_q      <= '0;
      col_q      <= '0;
      rd_tag_q   <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      k_q        <= k_d;
      row_q      <= row_d;
      col_q      <= col_d;
      rd_tag_q   <= rd_tag_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q  <= mac_result;
      out_last_q <= elem_last;
    end
  end

  // --- stores: writes only in load, reads only in compute, so the FSM
  //     itself is the interlock and no forwarding is needed ---------------
  mm4_store #(
    .DEPTH (ELEM_CNT),
    .WIDTH (ELEM_W)
  ) u_left_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && is_left),
    .waddr_i (load_cnt_q[AW-1:0]),
    .wdata_i (elem_i.element_value),
    .raddr_i (left_raddr),
    .rdata_o (left_rdata)
  );

  mm4_store #(
    .DEPTH (ELEM_CNT),
    .WIDTH (ELEM_W)
  ) u_right_store (
    .clk_i   (clk_i),
    .we_i    (in_acc && !is_left),
    .waddr_i (right_cnt[AW-1:0]),
    .wdata_i (elem_i.element_value),
    .raddr_i (right_raddr),
    .rdata_o (right_rdata)
  );

  mm4_mac #(
    .MATRIX_DIM (MATRIX_DIM),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tag_i    (rd_tag_q),
    .a_i      (left_rdata),
    .b_i      (right_rdata),
    .clr_i    (out_load),
    .done_o   (mac_done),
    .result_o (mac_result)
  );

  assign prod_o.valid         = out_vld_q;
  assign prod_o.product_value = out_val_q;
  assign prod_o.product_last  = out_last_q;

endmodule

// File: rtl/core/mm4_checker.sv
// ----------------------------------------------------------------------------
// mm4_checker
// Port-level checks of the matrix multiply unit, bound to the top level.
// ----------------------------------------------------------------------------
module mm4_checker #(
  parameter int unsigned MATRIX_DIM = mm4_pkg::MATRIX_DIM_DEF
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [mm4_pkg::ELEM_W-1:0] out_value_i,
  input logic                       out_last_i
);

  localparam int unsigned ELEM_CNT = MATRIX_DIM * MATRIX_DIM;
  localparam int unsigned ICW      = $clog2(2 * ELEM_CNT);
  localparam int unsigned OCW      = $clog2(ELEM_CNT);
  localparam int unsigned OWW      = $clog2(2 * ELEM_CNT + 2);

  logic            in_acc, out_acc, batch_done;
  logic [ICW-1:0]  in_cnt_q;
  logic [OCW-1:0]  out_cnt_q;
  logic [OWW-1:0]  owed_q, owed_d;

  assign in_acc     = in_valid_i && in_ready_i;
  assign out_acc    = out_valid_i && out_ready_i;
  assign batch_done = in_acc && (in_cnt_q == ICW'(2 * ELEM_CNT - 1));

  always_comb begin
    owed_d = owed_q;
    if (batch_done) begin
      owed_d = owed_d + OWW'(ELEM_CNT);
    end
    if (out_acc) begin
      owed_d = owed_d - OWW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      owed_q    <= '0;
    end else begin
      owed_q <= owed_d;
      if (in_acc) begin
        in_cnt_q <= batch_done ? '0 : in_cnt_q + ICW'(1);
      end
      if (out_acc) begin
        out_cnt_q <= (out_cnt_q == OCW'(ELEM_CNT - 1)) ? '0 : out_cnt_q + OCW'(1);
      end
    end
  end

  // stalled product word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) && $stable(out_last_i))
    else $error("product word changed while stalled");

  // last flag exactly on the final word of each batch
  a_last_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> (out_last_i == (out_cnt_q == OCW'(ELEM_CNT - 1))))
    else $error("product_last misplaced");

  // no product word without a completed batch behind it
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (owed_q != '0))
    else $error("product word without loaded matrices");

  // loading resumes only once at most the final word is pending
  a_load_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (owed_q <= OWW'(1)))
    else $error("element accepted during product streaming");

endmodule

bind matrix4_multiply_unit mm4_checker #(
  .MATRIX_DIM (MATRIX_DIM)
) u_mm4_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (elem_i.valid),
  .in_ready_i  (elem_i.ready),
  .out_valid_i (prod_o.valid),
  .out_ready_i (prod_o.ready),
  .out_value_i (prod_o.product_value),
  .out_last_i  (prod_o.product_last)
);
